/* sv/kwpr_pkg.sv */
`default_nettype none

package kwpr_pkg;

    // high nibble of data byte 1
    localparam logic [3:0] NIB_SINGLE = 4'h0;
    localparam logic [3:0] NIB_FIRST  = 4'h1;
    localparam logic [3:0] NIB_CONSEC = 4'h2;
    localparam logic [3:0] NIB_FLOW   = 4'h3;

    typedef enum logic [2:0] {
        KIND_SINGLE  = 3'd0,
        KIND_FIRST   = 3'd1,
        KIND_CONSEC  = 3'd2,
        KIND_FLOW    = 3'd3,
        KIND_INVALID = 3'd4
    } t_kind;

    // payload byte slots per frame kind
    localparam int          NUM_SLOTS    = 6;
    localparam logic [2:0]  SF_MAX_BYTES = 3'd5;
    localparam logic [2:0]  FF_SLOTS     = 3'd4;
    localparam logic [2:0]  CF_SLOTS     = 3'd6;

    localparam logic [11:0] RST_MSG_LEN     = 12'd2;
    localparam logic [11:0] RST_PAYLOAD_LEN = 12'd1;

    typedef struct packed {
        logic [10:0] can_id;
        logic [7:0]  data_0;
        logic [7:0]  data_1;
        logic [7:0]  data_2;
        logic [7:0]  data_3;
        logic [7:0]  data_4;
        logic [7:0]  data_5;
        logic [7:0]  data_6;
        logic [7:0]  data_7;
    } t_frame;

    typedef struct packed {
        t_kind       frame_kind;
        logic [7:0]  sender_addr;
        logic [7:0]  target_addr;
        logic [7:0]  service_id;
        logic [11:0] message_length;
        logic        byte_valid;
        logic [11:0] byte_index;
        logic [7:0]  byte_value;
        logic        message_complete;
        logic        sequence_error;
        logic        last;
    } t_result;

    // one classified frame, waiting to be serialized
    typedef struct packed {
        t_kind                          kind;
        logic [7:0]                     sender;
        logic [7:0]                     target;
        logic [7:0]                     sid;
        logic [11:0]                    msg_len;
        logic                           done;
        logic                           err;
        logic [11:0]                    start;
        logic [2:0]                     count;
        logic [NUM_SLOTS-1:0][7:0]      bytes;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* sv/kwpr_ifs.sv */
`default_nettype none

interface kwpr_frame_if import kwpr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frame data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kwpr_result_if import kwpr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/kwp_can_frame_reassembler.sv */
// channel   | dir | modport | carries
// ----------+-----+---------+-------------------------------------------
// i_frame   | in  | sink    | can id and eight data bytes, one frame
// o_result  | out | source  | one payload byte or a bare status result
//
// each frame yields max(1, new payload bytes) results, so 1 to 6 results, one
// per cycle while o_result is not stalled; the back end serializer sets this
// frames are classified and the reassembly state updated at the frame transfer
// a short descriptor queue lets frames be taken while results are stalled
// each result passes the descriptor queue and then the output register
// reset is synchronous active low and clears the state, queue and output valid
`default_nettype none

module kwp_can_frame_reassembler import kwpr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    kwpr_frame_if.sink    i_frame,
    kwpr_result_if.source o_result
);

    // front to queue
    logic    push;
    t_desc   push_desc;
    // queue to back
    logic    pop;
    t_desc   head_desc;
    t_q_stat q_stat;

    // front end: classify the frame, update reassembly state, build descriptor
    kwpr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (i_frame),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    // descriptor queue decouples frame intake from result output
    kwpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_desc)
    );

    // back end: walk the descriptor bytes into the output register
    kwpr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head_desc),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* sv/kwpr_front.sv */
`default_nettype none

module kwpr_front import kwpr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kwpr_frame_if.sink  i_frame,
    input  wire t_q_stat i_q_stat,
    output logic        o_push,
    output t_desc       o_desc
);

    logic        r_rx_done, n_rx_done;
    logic [11:0] r_msg_len, n_msg_len;
    logic [11:0] r_payload_len, n_payload_len;
    logic [11:0] r_cursor, n_cursor;
    logic [7:0]  r_sid, n_sid;

    logic [3:0]  nib;
    t_kind       kind;
    logic [7:0]  sf_pl8;
    logic [2:0]  sf_pl;
    logic [11:0] ff_len;
    logic [11:0] ff_pl;
    logic [11:0] cf_rem;
    logic [2:0]  cnt;
    logic        err;

    assign i_frame.ready = !i_q_stat.full;
    assign o_push        = i_frame.valid && !i_q_stat.full;

    assign nib = i_frame.data.data_1[7:4];

    always_comb begin
        unique case (nib)
            NIB_SINGLE: kind = KIND_SINGLE;
            NIB_FIRST:  kind = KIND_FIRST;
            NIB_CONSEC: kind = KIND_CONSEC;
            NIB_FLOW:   kind = KIND_FLOW;
            default:    kind = KIND_INVALID;
        endcase
    end

    // single frame: length is the whole byte, payload clamped
    assign sf_pl8 = (i_frame.data.data_1 == 8'd0) ? 8'd0 : i_frame.data.data_1 - 8'd1;
    assign sf_pl  = (sf_pl8 > {5'd0, SF_MAX_BYTES}) ? SF_MAX_BYTES : sf_pl8[2:0];

    // first frame: 12-bit length across bytes 1 and 2
    assign ff_len = {i_frame.data.data_1[3:0], i_frame.data.data_2};
    assign ff_pl  = (ff_len == 12'd0) ? 12'd0 : ff_len - 12'd1;

    assign cf_rem = r_payload_len - r_cursor;

    always_comb begin
        n_rx_done     = r_rx_done;
        n_msg_len     = r_msg_len;
        n_payload_len = r_payload_len;
        n_cursor      = r_cursor;
        n_sid         = r_sid;
        cnt           = 3'd0;
        err           = 1'b0;
        o_desc.bytes  = {i_frame.data.data_2, i_frame.data.data_3, i_frame.data.data_4,
                         i_frame.data.data_5, i_frame.data.data_6, i_frame.data.data_7};
        o_desc.start  = 12'd0;

        case (kind)
            KIND_SINGLE: begin
                if (!r_rx_done) begin
                    err = 1'b1;
                end else begin
                    n_msg_len     = {4'd0, i_frame.data.data_1};
                    n_payload_len = {9'd0, sf_pl};
                    n_sid         = i_frame.data.data_2;
                    n_cursor      = {9'd0, sf_pl};
                    cnt           = sf_pl;
                end
                o_desc.bytes = {i_frame.data.data_3, i_frame.data.data_4,
                                i_frame.data.data_5, i_frame.data.data_6,
                                i_frame.data.data_7, 8'd0};
            end
            KIND_FIRST: begin
                if (!r_rx_done) begin
                    err = 1'b1;
                end else begin
                    n_msg_len     = ff_len;
                    n_payload_len = ff_pl;
                    n_sid         = i_frame.data.data_3;
                    if (ff_pl > {9'd0, FF_SLOTS}) begin
                        cnt       = FF_SLOTS;
                        n_rx_done = 1'b0;
                    end else begin
                        cnt       = ff_pl[2:0];
                    end
                    n_cursor = {9'd0, cnt};
                end
                o_desc.bytes = {i_frame.data.data_4, i_frame.data.data_5,
                                i_frame.data.data_6, i_frame.data.data_7, 16'd0};
            end
            KIND_CONSEC: begin
                if (r_rx_done) begin
                    err = 1'b1;
                end else begin
                    o_desc.start = r_cursor;
                    if (r_cursor >= r_payload_len) begin
                        n_rx_done = 1'b1;
                    end else if (cf_rem > {9'd0, CF_SLOTS}) begin
                        cnt = CF_SLOTS;
                    end else begin
                        cnt       = cf_rem[2:0];
                        n_rx_done = 1'b1;
                    end
                    n_cursor = r_cursor + {9'd0, cnt};
                end
            end
            default: begin
            end
        endcase

        // bytes are stored with the first byte in the top slot, NUM_SLOTS-1
        o_desc.kind    = kind;
        o_desc.sender  = i_frame.data.can_id[7:0];
        o_desc.target  = i_frame.data.data_0;
        o_desc.sid     = n_sid;
        o_desc.msg_len = n_msg_len;
        o_desc.done    = n_rx_done;
        o_desc.err     = err;
        o_desc.count   = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_done     <= 1'b1;
            r_msg_len     <= RST_MSG_LEN;
            r_payload_len <= RST_PAYLOAD_LEN;
            r_cursor      <= 12'd0;
            r_sid         <= 8'd0;
        end else if (o_push) begin
            r_rx_done     <= n_rx_done;
            r_msg_len     <= n_msg_len;
            r_payload_len <= n_payload_len;
            r_cursor      <= n_cursor;
            r_sid         <= n_sid;
        end
    end

endmodule

`default_nettype wire

/* sv/kwpr_queue.sv */
`default_nettype none

module kwpr_queue import kwpr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output t_q_stat    o_stat,
    output t_desc      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/kwpr_back.sv */
`default_nettype none

module kwpr_back import kwpr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_desc   i_head,
    output logic         o_pop,
    kwpr_result_if.source o_result
);

    logic [2:0] r_k;
    logic       r_valid;
    t_result    r_out;
    logic       load;
    logic       has_bytes;
    logic       is_last;

    assign load      = !i_q_stat.empty && (!r_valid || o_result.ready);
    assign has_bytes = (i_head.count != 3'd0);
    assign is_last   = !has_bytes || (r_k == i_head.count - 3'd1);
    assign o_pop     = load && is_last;

    assign o_result.valid = r_valid;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.frame_kind       <= i_head.kind;
            r_out.sender_addr      <= i_head.sender;
            r_out.target_addr      <= i_head.target;
            r_out.service_id       <= i_head.sid;
            r_out.message_length   <= i_head.msg_len;
            r_out.byte_valid       <= has_bytes;
            r_out.byte_index       <= has_bytes ? i_head.start + {9'd0, r_k} : 12'd0;
            r_out.byte_value       <= has_bytes ? i_head.bytes[NUM_SLOTS-1-r_k] : 8'd0;
            r_out.message_complete <= i_head.done;
            r_out.sequence_error   <= i_head.err;
            r_out.last             <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= is_last ? 3'd0 : r_k + 3'd1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/kwpr_checker.sv */
`default_nettype none

module kwpr_checker import kwpr_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_out_valid,
    input wire logic    i_out_ready,
    input wire t_result i_out_data
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // a result without a byte is the only result of its frame
    a_bare_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.byte_valid |-> i_out_data.last)
        else $error("bare result not marked last");

    // out of order frames carry no byte
    a_err_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.sequence_error |->
            !i_out_data.byte_valid && (i_out_data.frame_kind == KIND_SINGLE ||
            i_out_data.frame_kind == KIND_FIRST || i_out_data.frame_kind == KIND_CONSEC))
        else $error("sequence error on unexpected result");

endmodule

bind kwp_can_frame_reassembler kwpr_checker u_kwpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

`default_nettype wire

/* tb/sv/kwp_can_frame_reassembler_test.sv */
`default_nettype none

// frame reassembler check
// - a directed script walks the frame kinds, the length extremes and the
//   out-of-order cases
// - a random part follows, mostly well-formed first/continuation runs with
//   random content and some out-of-order or ignored frames mixed in
// - any message still open is then finished, and a first frame of the
//   longest length the field allows closes the run
// - every frame transfer is run through a local reassembly model that
//   queues the results it should cause, and each result transfer is checked
//   field by field against the oldest queued result
module kwp_can_frame_reassembler_test import kwpr_pkg::*; ();

    localparam int NUM_SCRIPT    = 21;
    localparam int RANDOM_FRAMES = 185;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES  = 20;    // margin for the queue and the output register

    localparam t_result NO_WANT = '0;

    // one script row: id, data bytes 0..7 left to right, and an expected
    // result typed in by hand where the frame causes a single bare result
    typedef struct {
        logic [10:0] id;
        logic [63:0] bytes;
        bit          typed;
        t_result     want;
    } t_script_row;

    logic clk = 1'b0;
    logic rst_n;

    kwpr_frame_if  frame_if();
    kwpr_result_if result_if();

    kwp_can_frame_reassembler u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_frame  (frame_if),
        .o_result (result_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // reassembly state as the block should hold it
    logic        rx_open_n;     // 1 when no multi-frame message is open
    logic [11:0] rx_msg_len;
    logic [11:0] rx_payload_len;
    logic [11:0] rx_cursor;
    logic [7:0]  rx_sid;

    t_result expected_results[$];
    int      failures;
    int      sender_gap_pct;
    int      result_stall_pct;
    int      quiet_cycles;
    t_result got_result;
    t_result want_result;

    t_script_row script [NUM_SCRIPT] = '{
        // flow control right after reset
        '{11'h7FF, 64'hFF30_0000_0000_0000, 1'b1,
          '{KIND_FLOW, 8'hFF, 8'hFF, 8'h00, 12'd2, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        // continuation with no message open
        '{11'h000, 64'h002F_0000_0000_0000, 1'b1,
          '{KIND_CONSEC, 8'h00, 8'h00, 8'h00, 12'd2, 1'b0, 12'd0, 8'h00, 1'b1, 1'b1, 1'b1}},
        // invalid kinds, top and bottom of the invalid range
        '{11'h155, 64'hAAF0_FFFF_FFFF_FFFF, 1'b1,
          '{KIND_INVALID, 8'h55, 8'hAA, 8'h00, 12'd2, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        '{11'h2AA, 64'h554F_5555_5555_5555, 1'b1,
          '{KIND_INVALID, 8'hAA, 8'h55, 8'h00, 12'd2, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        // single frame of length zero, then of length one: no payload bytes
        '{11'h123, 64'h0100_AB11_2233_4455, 1'b1,
          '{KIND_SINGLE, 8'h23, 8'h01, 8'hAB, 12'd0, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        '{11'h124, 64'h0201_CD11_2233_4455, 1'b1,
          '{KIND_SINGLE, 8'h24, 8'h02, 8'hCD, 12'd1, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        // single frames: full five bytes, length fifteen clamped to five, two bytes
        '{11'h3C0, 64'h0306_01A0_A1A2_A3A4, 1'b0, NO_WANT},
        '{11'h3C1, 64'h040F_02B0_B1B2_B3B4, 1'b0, NO_WANT},
        '{11'h3C2, 64'h0503_0390_9192_9394, 1'b0, NO_WANT},
        // first frame of length zero and one close at once with no bytes
        '{11'h0FF, 64'h0510_00EE_0000_0000, 1'b1,
          '{KIND_FIRST, 8'hFF, 8'h05, 8'hEE, 12'd0, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        '{11'h001, 64'h0610_015A_0102_0304, 1'b1,
          '{KIND_FIRST, 8'h01, 8'h06, 8'h5A, 12'd1, 1'b0, 12'd0, 8'h00, 1'b1, 1'b0, 1'b1}},
        // first frames that complete inside the frame
        '{11'h500, 64'h0710_0322_C0C1_C2C3, 1'b0, NO_WANT},
        '{11'h501, 64'h0710_0523_C4C5_C6C7, 1'b0, NO_WANT},
        // first frame that opens a twenty byte message
        '{11'h502, 64'h0810_1431_D0D1_D2D3, 1'b0, NO_WANT},
        // first, single and flow control frames while it is open
        '{11'h600, 64'h091F_FF77_0000_0000, 1'b1,
          '{KIND_FIRST, 8'h00, 8'h09, 8'h31, 12'd20, 1'b0, 12'd0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{11'h3FF, 64'h0A07_1122_3344_5566, 1'b1,
          '{KIND_SINGLE, 8'hFF, 8'h0A, 8'h31, 12'd20, 1'b0, 12'd0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{11'h400, 64'h0B3A_0000_0000_0000, 1'b1,
          '{KIND_FLOW, 8'h00, 8'h0B, 8'h31, 12'd20, 1'b0, 12'd0, 8'h00, 1'b0, 1'b0, 1'b1}},
        // continuations: two full ones, then three bytes that close it
        '{11'h503, 64'h0821_E0E1_E2E3_E4E5, 1'b0, NO_WANT},
        '{11'h504, 64'h0822_F0F1_F2F3_F4F5, 1'b0, NO_WANT},
        '{11'h505, 64'h0823_A0A1_A2A3_A4A5, 1'b0, NO_WANT},
        // continuation after completion
        '{11'h2F0, 64'h0C2F_0000_0000_0000, 1'b1,
          '{KIND_CONSEC, 8'hF0, 8'h0C, 8'h31, 12'd20, 1'b0, 12'd0, 8'h00, 1'b1, 1'b1, 1'b1}}
    };

    // advance the reassembly state by one frame and queue the results it
    // causes; hand-typed rows queue their typed result instead
    function automatic void predict_frame(input t_frame frm, input bit typed,
                                          input t_result want);
        t_result     run[$];
        t_result     r;
        logic [7:0]  slot [8];
        logic [3:0]  nib;
        t_kind       kind;
        bit          take;
        bit          err;
        int          first_slot;
        int          i;

        slot = '{frm.data_0, frm.data_1, frm.data_2, frm.data_3,
                 frm.data_4, frm.data_5, frm.data_6, frm.data_7};
        nib  = frm.data_1[7:4];
        kind = (nib > NIB_FLOW) ? KIND_INVALID : t_kind'({1'b0, nib[1:0]});
        take = 1'b0;
        err  = 1'b0;
        first_slot = 8;

        case (kind)
            KIND_SINGLE: begin
                // single frames only start while nothing is open
                take = rx_open_n;
                if (take) begin
                    rx_msg_len     = {4'h0, frm.data_1};
                    rx_payload_len = (rx_msg_len == 12'd0) ? 12'd0 : rx_msg_len - 12'd1;
                    if (rx_payload_len > 12'(SF_MAX_BYTES))
                        rx_payload_len = 12'(SF_MAX_BYTES);
                    rx_sid     = frm.data_2;
                    rx_cursor  = 12'd0;
                    first_slot = 3;
                end
            end
            KIND_FIRST: begin
                take = rx_open_n;
                if (take) begin
                    rx_msg_len     = {frm.data_1[3:0], frm.data_2};
                    rx_payload_len = (rx_msg_len == 12'd0) ? 12'd0 : rx_msg_len - 12'd1;
                    rx_sid     = frm.data_3;
                    rx_cursor  = 12'd0;
                    first_slot = 4;
                end
            end
            KIND_CONSEC: begin
                // sequence number in the low nibble is not looked at
                take = !rx_open_n;
                if (take)
                    first_slot = 2;
            end
            default: ;
        endcase
        err = (kind inside {KIND_SINGLE, KIND_FIRST, KIND_CONSEC}) && !take;

        for (i = first_slot; i < 8 && rx_cursor < rx_payload_len; i++) begin
            r             = '0;
            r.frame_kind  = kind;
            r.sender_addr = frm.can_id[7:0];
            r.target_addr = frm.data_0;
            r.byte_valid  = 1'b1;
            r.byte_index  = rx_cursor;
            r.byte_value  = slot[i];
            run.push_back(r);
            rx_cursor = rx_cursor + 12'd1;
        end
        // completion is marked in the frame that delivers the last byte
        if (take && kind != KIND_SINGLE)
            rx_open_n = (rx_cursor >= rx_payload_len);

        if (run.size() == 0) begin
            r                = '0;
            r.frame_kind     = kind;
            r.sender_addr    = frm.can_id[7:0];
            r.target_addr    = frm.data_0;
            r.sequence_error = err;
            run.push_back(r);
        end

        // status fields show the state after the frame on every result
        foreach (run[k]) begin
            run[k].service_id       = rx_sid;
            run[k].message_length   = rx_msg_len;
            run[k].message_complete = rx_open_n;
            run[k].last             = (k == run.size() - 1);
        end

        if (typed)
            expected_results.push_back(want);
        else
            foreach (run[k])
                expected_results.push_back(run[k]);
    endfunction

    // present one frame, holding valid across back to back transfers
    task automatic send_frame(input t_frame frm, input bit typed, input t_result want);
        if ($urandom_range(99) < sender_gap_pct) begin
            frame_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
        end
        frame_if.valid <= 1'b1;
        frame_if.data  <= frm;
        do @(posedge clk); while (!frame_if.ready);
        predict_frame(frm, typed, want);
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge clk) begin
        if (rst_n && result_if.valid && result_if.ready) begin
            got_result = result_if.data;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d index %0h",
                       got_result.frame_kind, got_result.byte_index);
                failures++;
            end else begin
                want_result = expected_results.pop_front();
                compare_field("frame_kind", 12'(want_result.frame_kind),
                              12'(got_result.frame_kind));
                compare_field("sender_addr", 12'(want_result.sender_addr),
                              12'(got_result.sender_addr));
                compare_field("target_addr", 12'(want_result.target_addr),
                              12'(got_result.target_addr));
                compare_field("service_id", 12'(want_result.service_id),
                              12'(got_result.service_id));
                compare_field("message_length", want_result.message_length,
                              got_result.message_length);
                compare_field("byte_valid", 12'(want_result.byte_valid),
                              12'(got_result.byte_valid));
                compare_field("byte_index", want_result.byte_index,
                              got_result.byte_index);
                compare_field("byte_value", 12'(want_result.byte_value),
                              12'(got_result.byte_value));
                compare_field("message_complete", 12'(want_result.message_complete),
                              12'(got_result.message_complete));
                compare_field("sequence_error", 12'(want_result.sequence_error),
                              12'(got_result.sequence_error));
                compare_field("last", 12'(want_result.last), 12'(got_result.last));
            end
        end
        result_if.ready <= ($urandom_range(99) >= result_stall_pct);
    end

    // watchdog: a run of cycles with no transfer on either side ends the run
    always @(posedge clk) begin
        if (!rst_n || (frame_if.valid && frame_if.ready) ||
            (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_frame frm;
        int     pick;
        int     len_pick;
        int     n;
        logic [11:0] len;

        rst_n            = 1'b0;
        frame_if.valid   = 1'b0;
        frame_if.data    = '0;
        result_if.ready  = 1'b0;
        failures         = 0;
        quiet_cycles     = 0;
        // reset state of the reassembly model
        rx_open_n        = 1'b1;
        rx_msg_len       = RST_MSG_LEN;
        rx_payload_len   = RST_PAYLOAD_LEN;
        rx_cursor        = 12'd0;
        rx_sid           = 8'h00;
        // first phase: sender idles less than the receiver stalls
        sender_gap_pct   = 26;
        result_stall_pct = 48;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed script
        foreach (script[s])
            send_frame(t_frame'({script[s].id, script[s].bytes}),
                       script[s].typed, script[s].want);

        // random part: mostly well-formed messages, some frames out of order
        for (n = 0; n < RANDOM_FRAMES; n++) begin
            if (n == RANDOM_FRAMES / 3) begin
                sender_gap_pct   = 48;
                result_stall_pct = 26;
            end else if (n == 2 * RANDOM_FRAMES / 3) begin
                sender_gap_pct   = 0;
                result_stall_pct = 0;
            end
            frm  = t_frame'({11'($urandom), $urandom, $urandom});
            pick = $urandom_range(99);
            if (rx_open_n) begin
                if (pick < 55) begin
                    // open a new message, short most of the time
                    len_pick = $urandom_range(99);
                    if (len_pick < 4)
                        len = 12'd0;
                    else if (len_pick < 88)
                        len = 12'($urandom_range(1, 40));
                    else
                        len = 12'($urandom_range(41, 300));
                    frm.data_1 = {NIB_FIRST, len[11:8]};
                    frm.data_2 = len[7:0];
                end else if (pick < 80) begin
                    frm.data_1[7:4] = NIB_SINGLE;
                end else begin
                    // stray continuation, flow control or invalid kind
                    frm.data_1[7:4] = 4'($urandom_range(2, 15));
                end
            end else begin
                if (pick < 78)
                    frm.data_1[7:4] = NIB_CONSEC;
                else
                    frm.data_1[7:4] = 4'($urandom_range(15));
            end
            send_frame(frm, 1'b0, NO_WANT);
        end

        // finish any open message with random continuation content
        while (!rx_open_n) begin
            frm         = t_frame'({11'($urandom), $urandom, $urandom});
            frm.data_1  = {NIB_CONSEC, frm.data_1[3:0]};
            send_frame(frm, 1'b0, NO_WANT);
        end

        // first frame of the longest length the field allows
        frm = t_frame'({11'h7FF, 64'h7F1F_FF80_FF00_FF00});
        send_frame(frm, 1'b0, NO_WANT);
        frame_if.valid <= 1'b0;

        // wait for the tail, then give late extra results a chance to show
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
